@@ rtl/core/sbiu_pkg.sv @@
// sbiu_pkg: shared constants, codes and control types of the scoreboard issue unit
// used by the interfaces, controller, datapath, top level and checker
package sbiu_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned PIPES_DEF = 4;
  localparam int unsigned REGS_DEF  = 32;

  // field widths
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned PIPE_W  = 2;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned OUTC_W  = 2;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned UNITS   = 4;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ISSUE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNIT_DONE = 2'd2;

  // instruction classes
  localparam logic [CLS_W-1:0] CLS_ALU    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_BRANCH = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LDST   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd3;

  // unit slots
  localparam logic [SLOT_W-1:0] SLOT_ALU0   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_ALU1   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_BRANCH = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_LDST   = 2'd3;

  // result outcomes
  localparam logic [OUTC_W-1:0] OUTC_ISSUED  = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_STALLED = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_BLOCKED = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_DONE    = 2'd3;

  localparam logic [AGE_W-1:0]  AGE_MAX   = '1;
  localparam logic [UNITS-1:0]  BUSY_ALL  = '1;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture the accepted item
    logic scan_first;  // first step of the age scan
    logic scan_en;     // one step of the age scan
    logic commit;      // update state and write the result register
  } sbiu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a new result
  } sbiu_status_t;

endpackage

@@ rtl/core/sbiu_in_if.sv @@
// sbiu_in_if: input channel of the scoreboard issue unit, one decoded item per transfer
// depends on sbiu_pkg for field widths
interface sbiu_in_if import sbiu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PIPE_W-1:0] pipe;
  logic [CLS_W-1:0]  instr_class;
  logic              is_halt;
  logic              is_load_imm;
  logic [REG_W-1:0]  dest_reg;
  logic [REG_W-1:0]  src1_reg;
  logic [REG_W-1:0]  src2_reg;
  logic [SLOT_W-1:0] done_slot;

  modport source (
    output valid, action, pipe, instr_class, is_halt, is_load_imm,
           dest_reg, src1_reg, src2_reg, done_slot,
    input  ready
  );
  modport sink (
    input  valid, action, pipe, instr_class, is_halt, is_load_imm,
           dest_reg, src1_reg, src2_reg, done_slot,
    output ready
  );
endinterface

@@ rtl/core/sbiu_out_if.sv @@
// sbiu_out_if: result channel of the scoreboard issue unit, one result per transfer
// depends on sbiu_pkg for field widths
interface sbiu_out_if import sbiu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] outcome;
  logic [SLOT_W-1:0] slot_used;
  logic [AGE_W-1:0]  pipe_age;

  modport source (output valid, outcome, slot_used, pipe_age, input ready);
  modport sink   (input valid, outcome, slot_used, pipe_age, output ready);
endinterface

@@ rtl/core/sbiu_ctrl.sv @@
// sbiu_ctrl: sequencer of the scoreboard issue unit (accept, age scan, commit)
// depends on sbiu_pkg for the command and status types
module sbiu_ctrl import sbiu_pkg::*; #(
  parameter int unsigned PIPES = PIPES_DEF,
  localparam int unsigned PW   = (PIPES > 1) ? $clog2(PIPES) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sbiu_status_t status_i,
  output sbiu_cmd_t    cmd_o,
  output logic [PW-1:0] scan_idx_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  localparam logic [PW-1:0] LAST_PIPE = PW'(PIPES - 1);

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_idx_o = cnt_q;

  // next state and commands
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o.load       = 1'b0;
    cmd_o.scan_first = 1'b0;
    cmd_o.scan_en    = 1'b0;
    cmd_o.commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.scan_first = (cnt_q == '0);
        if (cnt_q == LAST_PIPE) begin
          state_d = ST_EXEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/core/sbiu_dpath.sv @@
// sbiu_dpath: scoreboard state, age scan, issue decision and result register
// depends on sbiu_pkg and the sbiu_out_if interface
module sbiu_dpath import sbiu_pkg::*; #(
  parameter int unsigned PIPES = PIPES_DEF,
  parameter int unsigned REGS  = REGS_DEF,
  localparam int unsigned PW   = (PIPES > 1) ? $clog2(PIPES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbiu_cmd_t         cmd_i,
  output sbiu_status_t      status_o,
  input  logic [PW-1:0]     scan_idx_i,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [PIPE_W-1:0] pipe_i,
  input  logic [CLS_W-1:0]  instr_class_i,
  input  logic              is_halt_i,
  input  logic              is_load_imm_i,
  input  logic [REG_W-1:0]  dest_reg_i,
  input  logic [REG_W-1:0]  src1_reg_i,
  input  logic [REG_W-1:0]  src2_reg_i,
  input  logic [SLOT_W-1:0] done_slot_i,
  sbiu_out_if.source        out_o
);

  localparam int unsigned RW = $clog2(REGS);

  // captured item
  logic [ACT_W-1:0]  act_q;
  logic [PIPE_W-1:0] pipe_q;
  logic [CLS_W-1:0]  cls_q;
  logic              halt_q, ldi_q;
  logic [REG_W-1:0]  rd_q, rs1_q, rs2_q;
  logic [SLOT_W-1:0] dslot_q;

  // scoreboard state
  logic [REGS-1:0]  reg_ready_q, reg_ready_d;
  logic [UNITS-1:0] busy_q [PIPES];
  logic [UNITS-1:0] busy_d [PIPES];
  logic [AGE_W-1:0] age_q  [PIPES];
  logic [AGE_W-1:0] age_d  [PIPES];
  logic [PIPES-1:0] occ_q, occ_d;
  logic [AGE_W-1:0] max_q, max_d;

  // result register
  logic              out_valid_q;
  logic [OUTC_W-1:0] outc_q, outc_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [AGE_W-1:0]  rage_q, rage_d;

  logic          pipe_ok;
  logic [PW-1:0] pidx;
  logic [RW-1:0] rd_idx, rs1_idx, rs2_idx;
  logic          ok_rd, ok_rs1, ok_rs2, src_ready, pass;
  logic [UNITS-1:0] busy_cur;
  logic [AGE_W-1:0] age_cur, scan_base;
  logic [SLOT_W-1:0] take;
  logic          take_ok;

  assign status_o.out_free = !out_valid_q || out_o.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.outcome   = outc_q;
  assign out_o.slot_used = slot_q;
  assign out_o.pipe_age  = rage_q;

  // index decode; registers beyond the file read as ready
  assign pipe_ok  = 32'(pipe_q) < PIPES;
  assign pidx     = PW'(pipe_q);
  assign rd_idx   = RW'(rd_q);
  assign rs1_idx  = RW'(rs1_q);
  assign rs2_idx  = RW'(rs2_q);
  assign ok_rd    = (32'(rd_q)  >= REGS) || reg_ready_q[rd_idx];
  assign ok_rs1   = (32'(rs1_q) >= REGS) || reg_ready_q[rs1_idx];
  assign ok_rs2   = (32'(rs2_q) >= REGS) || reg_ready_q[rs2_idx];
  assign busy_cur = pipe_ok ? busy_q[pidx] : '0;
  assign age_cur  = pipe_ok ? age_q[pidx]  : '0;

  // per-class operand readiness
  always_comb begin
    case (cls_q)
      CLS_ALU:    src_ready = ok_rd && ok_rs1 && ok_rs2;
      CLS_BRANCH: src_ready = halt_q || (ok_rs1 && ok_rs2);
      CLS_LDST:   src_ready = ok_rd && (ldi_q || ok_rs1);
      default:    src_ready = 1'b0;
    endcase
  end

  // slot choice for the class
  always_comb begin
    take    = SLOT_ALU0;
    take_ok = 1'b0;
    case (cls_q)
      CLS_ALU: begin
        if (!busy_cur[SLOT_ALU0]) begin
          take    = SLOT_ALU0;
          take_ok = src_ready;
        end else if (!busy_cur[SLOT_ALU1]) begin
          take    = SLOT_ALU1;
          take_ok = src_ready;
        end
      end
      CLS_BRANCH: begin
        take    = SLOT_BRANCH;
        take_ok = src_ready && !busy_cur[SLOT_BRANCH];
      end
      CLS_LDST: begin
        take    = SLOT_LDST;
        take_ok = src_ready && !busy_cur[SLOT_LDST];
      end
      default: begin
        take_ok = 1'b0;
      end
    endcase
  end

  // issue check: ready operands on an already waiting pipe, or oldest-first against the scanned maximum age
  assign pass = (src_ready && (age_cur != '0)) || (age_cur == max_q);

  // age scan step: the attempting pipe counts as occupied
  assign scan_base = cmd_i.scan_first ? '0 : max_q;
  always_comb begin
    max_d = scan_base;
    if ((occ_q[scan_idx_i] || (32'(scan_idx_i) == 32'(pipe_q))) &&
        (age_q[scan_idx_i] > scan_base)) begin
      max_d = age_q[scan_idx_i];
    end
  end

  // state update and result of the step
  always_comb begin
    reg_ready_d = reg_ready_q;
    busy_d      = busy_q;
    age_d       = age_q;
    occ_d       = occ_q;
    outc_d      = OUTC_BLOCKED;
    slot_d      = SLOT_ALU0;
    case (act_q)
      ACT_RELEASE: begin
        if (32'(rd_q) < REGS) begin
          reg_ready_d[rd_idx] = 1'b1;
        end
        outc_d = OUTC_DONE;
      end
      ACT_UNIT_DONE: begin
        if (pipe_ok) begin
          busy_d[pidx] = busy_cur & ~(UNITS'(1) << dslot_q);
        end
        outc_d = OUTC_DONE;
      end
      ACT_ISSUE: begin
        if (pipe_ok && (cls_q != CLS_NONE)) begin
          occ_d[pidx] = 1'b1;
          if ((busy_cur != BUSY_ALL) && pass) begin
            if (take_ok) begin
              busy_d[pidx] = busy_cur | (UNITS'(1) << take);
              if ((cls_q != CLS_BRANCH) && (32'(rd_q) < REGS)) begin
                reg_ready_d[rd_idx] = 1'b0;
              end
              occ_d[pidx] = 1'b0;
              age_d[pidx] = '0;
              outc_d      = OUTC_ISSUED;
              slot_d      = take;
            end else begin
              if (age_cur != AGE_MAX) begin
                age_d[pidx] = age_cur + 1'b1;
              end
              outc_d = OUTC_STALLED;
            end
          end
        end
      end
      default: begin
        outc_d = OUTC_BLOCKED;
      end
    endcase
    rage_d = pipe_ok ? age_d[pidx] : '0;
  end

  // captured item, scan register and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      pipe_q  <= pipe_i;
      cls_q   <= instr_class_i;
      halt_q  <= is_halt_i;
      ldi_q   <= is_load_imm_i;
      rd_q    <= dest_reg_i;
      rs1_q   <= src1_reg_i;
      rs2_q   <= src2_reg_i;
      dslot_q <= done_slot_i;
    end
    if (cmd_i.scan_en) begin
      max_q <= max_d;
    end
    if (cmd_i.commit) begin
      outc_q <= outc_d;
      slot_q <= slot_d;
      rage_q <= rage_d;
    end
  end

  // scoreboard state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_ready_q <= '1;
      occ_q       <= '0;
      for (int i = 0; i < PIPES; i++) begin
        busy_q[i] <= '0;
        age_q[i]  <= '0;
      end
    end else if (cmd_i.commit) begin
      reg_ready_q <= reg_ready_d;
      occ_q       <= occ_d;
      busy_q      <= busy_d;
      age_q       <= age_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ rtl/core/scoreboard_issue_unit_top.sv @@
// scoreboard_issue_unit_top: scoreboard issue stage shared by several pipelines
// instantiates sbiu_ctrl and sbiu_dpath; uses sbiu_pkg, sbiu_in_if and sbiu_out_if
//
// usage:
//   in_i carries one action per transfer: an issue attempt for a pipeline, a
//   register release, or a unit slot completion. out_o carries exactly one
//   result per accepted item (outcome, slot taken, pipeline age), in order.
//   sequence: after the input transfer the controller walks the pipelines one
//   per cycle to find the oldest waiting age, then commits the scoreboard
//   update and the result once the result register is free.
//   overlap: the next item is taken as soon as the previous one has been
//   committed into the result register, even if that result is still
//   waiting; until then no new item is accepted.
//   stall: when out_o.ready is low, the finished result holds in the result
//   register; a following item runs its scan and then waits to commit.
//   reset: all registers read ready, all unit slots free, all ages zero,
//   no pipeline waiting, and no result pending.
module scoreboard_issue_unit_top import sbiu_pkg::*; #(
  parameter int unsigned PIPES = PIPES_DEF,
  parameter int unsigned REGS  = REGS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbiu_in_if.sink    in_i,
  sbiu_out_if.source out_o
);

  localparam int unsigned PW = (PIPES > 1) ? $clog2(PIPES) : 1;

  sbiu_cmd_t     cmd;
  sbiu_status_t  status;
  logic [PW-1:0] scan_idx;
  logic          in_ready;

  assign in_i.ready = in_ready;

  // sequencer
  sbiu_ctrl #(
    .PIPES (PIPES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  // scoreboard datapath
  sbiu_dpath #(
    .PIPES (PIPES),
    .REGS  (REGS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .scan_idx_i    (scan_idx),
    .action_i      (in_i.action),
    .pipe_i        (in_i.pipe),
    .instr_class_i (in_i.instr_class),
    .is_halt_i     (in_i.is_halt),
    .is_load_imm_i (in_i.is_load_imm),
    .dest_reg_i    (in_i.dest_reg),
    .src1_reg_i    (in_i.src1_reg),
    .src2_reg_i    (in_i.src2_reg),
    .done_slot_i   (in_i.done_slot),
    .out_o         (out_o)
  );

endmodule

@@ rtl/core/sbiu_checker.sv @@
// sbiu_checker: port-level assertions on the scoreboard issue unit, bound to the top
// depends on sbiu_pkg for the outcome codes
module sbiu_checker import sbiu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [OUTC_W-1:0] outcome_i,
  input logic [SLOT_W-1:0] slot_used_i,
  input logic [AGE_W-1:0]  pipe_age_i
);

  // a pending result stays until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item at a time: input closes right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  // a result other than an issue reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i != OUTC_ISSUED) |-> slot_used_i == '0)
    else $error("slot reported without issue");

  // an issue resets the age of its pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i == OUTC_ISSUED) |-> pipe_age_i == '0)
    else $error("age not cleared on issue");

endmodule

bind scoreboard_issue_unit_top sbiu_checker u_sbiu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .outcome_i   (out_o.outcome),
  .slot_used_i (out_o.slot_used),
  .pipe_age_i  (out_o.pipe_age)
);

@@ dv/tb_scoreboard_issue_unit_top.sv @@
// tb_scoreboard_issue_unit_top: self-checking bench for the scoreboard issue unit
// predicts each result from a local copy of the scoreboard and compares in order
// depends on sbiu_pkg, sbiu_in_if, sbiu_out_if and scoreboard_issue_unit_top
module tb_scoreboard_issue_unit_top import sbiu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPES      = PIPES_DEF;
  localparam int unsigned REGS       = REGS_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SAT_STALLS = 270;

  // action code with no effect on the scoreboard
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [PIPE_W-1:0] pipe;
    logic [CLS_W-1:0]  instr_class;
    logic              is_halt;
    logic              is_load_imm;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src1_reg;
    logic [REG_W-1:0]  src2_reg;
    logic [SLOT_W-1:0] done_slot;
    bit                drain_first;
  } issue_op_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot_used;
    logic [AGE_W-1:0]  pipe_age;
  } issue_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbiu_in_if  in_if ();
  sbiu_out_if out_if ();

  scoreboard_issue_unit_top #(
    .PIPES (PIPES),
    .REGS  (REGS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow scoreboard
  bit               reg_rdy    [REGS];
  logic [UNITS-1:0] slot_busy  [PIPES];
  logic [AGE_W-1:0] pipe_wait  [PIPES];
  bit               latch_full [PIPES];

  issue_op_t     pending_ops [$];
  issue_result_t outcome_q   [$];
  issue_op_t     drv_item;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned drv_gap = 0, drv_phase = 0, snk_stall = 0, snk_phase = 0;
  bit          drv_calm = 1'b0, snk_calm = 1'b0, drv_hold;

  function automatic bit reg_free(logic [REG_W-1:0] r);
    return (r >= REGS) || reg_rdy[r];
  endfunction

  // one scoreboard step: update the shadow state and return the expected result
  function automatic issue_result_t predict_issue(issue_op_t op);
    issue_result_t     res;
    logic [UNITS-1:0]  busy;
    logic [AGE_W-1:0]  oldest;
    logic [SLOT_W-1:0] slot;
    bit                pipe_ok, ready, pass, took;
    int                j;
    res.outcome   = OUTC_BLOCKED;
    res.slot_used = '0;
    pipe_ok       = op.pipe < PIPES;
    case (op.action)
      ACT_RELEASE: begin
        if (op.dest_reg < REGS) reg_rdy[op.dest_reg] = 1'b1;
        res.outcome = OUTC_DONE;
      end
      ACT_UNIT_DONE: begin
        if (pipe_ok) slot_busy[op.pipe] &= ~(UNITS'(1) << op.done_slot);
        res.outcome = OUTC_DONE;
      end
      ACT_ISSUE: begin
        if (pipe_ok && op.instr_class != CLS_NONE) begin
          latch_full[op.pipe] = 1'b1;
          busy = slot_busy[op.pipe];
          case (op.instr_class)
            CLS_ALU:    ready = reg_free(op.dest_reg) && reg_free(op.src1_reg) &&
                                reg_free(op.src2_reg);
            CLS_BRANCH: ready = op.is_halt || (reg_free(op.src1_reg) &&
                                reg_free(op.src2_reg));
            default:    ready = reg_free(op.dest_reg) &&
                                (op.is_load_imm || reg_free(op.src1_reg));
          endcase
          if (busy != BUSY_ALL) begin
            pass = ready && (pipe_wait[op.pipe] != 0);
            // fall back to the oldest waiting pipeline
            if (!pass) begin
              oldest = '0;
              for (j = 0; j < PIPES; j++)
                if (latch_full[j] && pipe_wait[j] > oldest) oldest = pipe_wait[j];
              pass = pipe_wait[op.pipe] == oldest;
            end
            if (pass) begin
              took = 1'b0;
              slot = SLOT_ALU0;
              if (ready) begin
                case (op.instr_class)
                  CLS_ALU: begin
                    if (!busy[SLOT_ALU0]) begin
                      took = 1'b1;
                      slot = SLOT_ALU0;
                    end else if (!busy[SLOT_ALU1]) begin
                      took = 1'b1;
                      slot = SLOT_ALU1;
                    end
                  end
                  CLS_BRANCH: begin
                    took = !busy[SLOT_BRANCH];
                    slot = SLOT_BRANCH;
                  end
                  default: begin
                    took = !busy[SLOT_LDST];
                    slot = SLOT_LDST;
                  end
                endcase
              end
              if (took) begin
                slot_busy[op.pipe] = busy | (UNITS'(1) << slot);
                if (op.instr_class != CLS_BRANCH && op.dest_reg < REGS)
                  reg_rdy[op.dest_reg] = 1'b0;
                latch_full[op.pipe] = 1'b0;
                pipe_wait[op.pipe]  = '0;
                res.outcome   = OUTC_ISSUED;
                res.slot_used = slot;
              end else begin
                if (pipe_wait[op.pipe] != AGE_MAX) pipe_wait[op.pipe]++;
                res.outcome = OUTC_STALLED;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.pipe_age = pipe_ok ? pipe_wait[op.pipe] : '0;
    return res;
  endfunction

  // idle length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(3, 1);
    else if (r < 98) return $urandom_range(12, 4);
    else return $urandom_range(48, 20);
  endfunction

  // register index biased toward a few registers so hazards are common
  function automatic logic [REG_W-1:0] pick_reg();
    logic [REG_W-1:0] r;
    if ($urandom_range(9) < 7) r = REG_W'($urandom_range(7));
    else r = REG_W'($urandom_range(31));
    return r;
  endfunction

  task automatic add_op(logic [ACT_W-1:0] a, logic [PIPE_W-1:0] p, logic [CLS_W-1:0] c,
                        bit h, bit l, logic [REG_W-1:0] rd, logic [REG_W-1:0] rs1,
                        logic [REG_W-1:0] rs2, logic [SLOT_W-1:0] ds, bit drain = 1'b0);
    issue_op_t op;
    op.action      = a;
    op.pipe        = p;
    op.instr_class = c;
    op.is_halt     = h;
    op.is_load_imm = l;
    op.dest_reg    = rd;
    op.src1_reg    = rs1;
    op.src2_reg    = rs2;
    op.done_slot   = ds;
    op.drain_first = drain;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_random_op(bit drain);
    int unsigned       r;
    logic [ACT_W-1:0]  a;
    logic [CLS_W-1:0]  c;
    r = $urandom_range(99);
    if (r < 55) a = ACT_ISSUE;
    else if (r < 77) a = ACT_RELEASE;
    else if (r < 95) a = ACT_UNIT_DONE;
    else a = ACT_NONE;
    r = $urandom_range(99);
    if (r < 40) c = CLS_ALU;
    else if (r < 65) c = CLS_BRANCH;
    else if (r < 95) c = CLS_LDST;
    else c = CLS_NONE;
    add_op(a, PIPE_W'($urandom_range(3)), c, 1'($urandom_range(1)), 1'($urandom_range(1)),
           pick_reg(), pick_reg(), pick_reg(), SLOT_W'($urandom_range(3)), drain);
  endtask

  // driver: present pending items, predict on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.action      <= '0;
      in_if.pipe        <= '0;
      in_if.instr_class <= '0;
      in_if.is_halt     <= 1'b0;
      in_if.is_load_imm <= 1'b0;
      in_if.dest_reg    <= '0;
      in_if.src1_reg    <= '0;
      in_if.src2_reg    <= '0;
      in_if.done_slot   <= '0;
      drv_gap = 0;
    end else begin
      drv_hold = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        outcome_q.insert(outcome_q.size(), predict_issue(drv_item));
        drv_hold = 1'b0;
        if (drv_phase == 0) begin
          drv_calm  = ($urandom_range(3) == 0);
          drv_phase = $urandom_range(150, 30);
        end else begin
          drv_phase--;
        end
        drv_gap = drv_calm ? 0 : pick_gap();
      end
      if (!drv_hold) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain_first && outcome_q.size() > 0)) begin
          drv_item = pending_ops.pop_front();
          drv_hold = 1'b1;
          in_if.action      <= drv_item.action;
          in_if.pipe        <= drv_item.pipe;
          in_if.instr_class <= drv_item.instr_class;
          in_if.is_halt     <= drv_item.is_halt;
          in_if.is_load_imm <= drv_item.is_load_imm;
          in_if.dest_reg    <= drv_item.dest_reg;
          in_if.src1_reg    <= drv_item.src1_reg;
          in_if.src2_reg    <= drv_item.src2_reg;
          in_if.done_slot   <= drv_item.done_slot;
        end
      end
      in_if.valid <= drv_hold;
    end
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (snk_phase == 0) begin
        snk_calm  = ($urandom_range(3) == 0);
        snk_phase = $urandom_range(300, 60);
      end else begin
        snk_phase--;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        out_if.ready <= 1'b0;
      end else begin
        snk_stall = (snk_calm || $urandom_range(2) != 0) ? 0 : pick_gap();
        out_if.ready <= (snk_stall == 0);
        if (snk_stall > 0) snk_stall--;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    issue_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result outcome %0d slot %0d age %0d", $time,
                 out_if.outcome, out_if.slot_used, out_if.pipe_age);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (out_if.outcome !== want.outcome || out_if.slot_used !== want.slot_used ||
            out_if.pipe_age !== want.pipe_age) begin
          $display("%0t: mismatch expected outcome %0d slot %0d age %0d, actual %0d %0d %0d",
                   $time, want.outcome, want.slot_used, want.pipe_age,
                   out_if.outcome, out_if.slot_used, out_if.pipe_age);
          mismatches++;
        end
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("tb_scoreboard_issue_unit_top failed");
    $finish;
  end

  initial begin
    int unsigned       k;
    int unsigned       r;
    logic [PIPE_W-1:0] sat_pipe;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = '0;
    in_if.pipe         = '0;
    in_if.instr_class  = '0;
    in_if.is_halt      = 1'b0;
    in_if.is_load_imm  = 1'b0;
    in_if.dest_reg     = '0;
    in_if.src1_reg     = '0;
    in_if.src2_reg     = '0;
    in_if.done_slot    = '0;
    out_if.ready       = 1'b0;
    for (k = 0; k < REGS; k++) reg_rdy[k] = 1'b1;
    for (k = 0; k < PIPES; k++) begin
      slot_busy[k]  = '0;
      pipe_wait[k]  = '0;
      latch_full[k] = 1'b0;
    end

    // directed: fill pipe 0 slot by slot, hazards, stalls and ignored attempts
    add_op(ACT_ISSUE, 0, CLS_ALU, 0, 0, 1, 2, 3, SLOT_ALU0);
    add_op(ACT_ISSUE, 0, CLS_ALU, 0, 0, 4, 1, 5, SLOT_ALU0);
    add_op(ACT_RELEASE, 0, CLS_ALU, 0, 0, 1, 0, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 0, CLS_ALU, 0, 0, 4, 1, 5, SLOT_ALU0);
    add_op(ACT_ISSUE, 0, CLS_BRANCH, 1, 0, 0, 4, 4, SLOT_ALU0);
    add_op(ACT_ISSUE, 0, CLS_LDST, 0, 1, 31, 1, 0, SLOT_ALU0);
    // every slot of pipe 0 busy
    add_op(ACT_ISSUE, 0, CLS_ALU, 0, 0, 10, 0, 0, SLOT_ALU0);
    add_op(ACT_NONE, 0, CLS_ALU, 0, 0, 0, 0, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 3, CLS_NONE, 1, 1, 31, 31, 31, SLOT_LDST);
    add_op(ACT_UNIT_DONE, 0, CLS_ALU, 0, 0, 0, 0, 0, SLOT_LDST);
    add_op(ACT_ISSUE, 0, CLS_LDST, 0, 0, 12, 31, 0, SLOT_ALU0);
    // younger pipeline, not eligible
    add_op(ACT_ISSUE, 1, CLS_BRANCH, 0, 0, 0, 31, 0, SLOT_ALU0);
    add_op(ACT_RELEASE, 0, CLS_ALU, 0, 0, 31, 0, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 1, CLS_BRANCH, 0, 0, 0, 31, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 0, CLS_LDST, 0, 0, 12, 31, 0, SLOT_ALU0);
    add_op(ACT_UNIT_DONE, 0, CLS_ALU, 0, 0, 0, 0, 0, SLOT_ALU0);
    add_op(ACT_UNIT_DONE, 0, CLS_ALU, 0, 0, 0, 0, 0, SLOT_ALU1);
    add_op(ACT_UNIT_DONE, 0, CLS_ALU, 0, 0, 0, 0, 0, SLOT_BRANCH);
    add_op(ACT_ISSUE, 1, CLS_BRANCH, 0, 0, 0, 31, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 2, CLS_ALU, 0, 0, 0, 0, 0, SLOT_ALU0);
    add_op(ACT_ISSUE, 3, CLS_ALU, 0, 0, 31, 31, 31, SLOT_ALU0);
    add_op(ACT_RELEASE, 3, CLS_NONE, 1, 1, 0, 31, 31, SLOT_LDST);
    add_op(ACT_UNIT_DONE, 3, CLS_NONE, 1, 1, 31, 31, 31, SLOT_ALU0);
    add_op(ACT_NONE, 3, CLS_NONE, 1, 1, 31, 31, 31, SLOT_LDST);

    // empty every latch with halts, two rounds settle any order of ages
    for (r = 0; r < 2; r++)
      for (k = 0; k < PIPES; k++) begin
        add_op(ACT_UNIT_DONE, PIPE_W'(k), CLS_ALU, 0, 0, 0, 0, 0, SLOT_BRANCH,
               (r == 0 && k == 0));
        add_op(ACT_ISSUE, PIPE_W'(k), CLS_BRANCH, 1, 0, 0, 0, 0, SLOT_ALU0);
      end
    // branch unit held busy: age climbs to saturation
    sat_pipe = PIPE_W'($urandom_range(PIPES - 1));
    for (k = 0; k < SAT_STALLS; k++)
      add_op(ACT_ISSUE, sat_pipe, CLS_BRANCH, 1, 1'($urandom_range(1)), pick_reg(),
             pick_reg(), pick_reg(), SLOT_W'($urandom_range(3)));
    add_op(ACT_UNIT_DONE, sat_pipe, CLS_ALU, 0, 0, 0, 0, 0, SLOT_BRANCH);
    add_op(ACT_ISSUE, sat_pipe, CLS_BRANCH, 1, 0, 0, 0, 0, SLOT_ALU0);

    // random traffic, with one pause for a full drain midway
    for (k = 0; k < 640; k++) add_random_op(k == 320);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || in_if.valid) @(posedge clk_i);
    while (outcome_q.size() > 0) @(posedge clk_i);
    repeat (2 * (PIPES + 2)) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0)
      $display("tb_scoreboard_issue_unit_top passed");
    else
      $display("tb_scoreboard_issue_unit_top failed");
    $finish;
  end

endmodule
